// File: design/bshf_pkg.sv
`default_nettype none
package bshf_pkg;

  localparam int unsigned FIFO_DEPTH = 4;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned COUNT_W = 3;
  localparam int unsigned LEN_W   = 31;

  // Mixing rule picked by the front from the byte count
  typedef enum logic [2:0] {
    KIND_NONE,
    KIND_ONE,
    KIND_TWO,
    KIND_THREE,
    KIND_FULL
  } kind_t;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    kind_t             kind;
    logic [LEN_W-1:0]  seed;
    logic              first;
    logic              last;
  } item_t;

  // One finished string on its way through the avalanche stages
  typedef struct packed {
    logic [WORD_W-1:0] hash;
    logic              zero;
  } fin_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic pop;
  } fifo_status_t;

  function automatic kind_t classify(input logic [COUNT_W-1:0] count);
    kind_t k;
    case (count)
      3'd0:    k = KIND_NONE;
      3'd1:    k = KIND_ONE;
      3'd2:    k = KIND_TWO;
      3'd3:    k = KIND_THREE;
      default: k = KIND_FULL;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] sext8(input logic [7:0] b);
    return {{24{b[7]}}, b};
  endfunction

  function automatic logic [31:0] mix_word(input logic [31:0] h_in,
                                           input logic [31:0] w,
                                           input kind_t       kind);
    logic [31:0] h;
    logic [31:0] t;
    h = h_in;
    t = '0;
    case (kind)
      KIND_FULL: begin
        h = h + {16'd0, w[15:0]};
        t = {16'd0, w[31:16]} << 11;
        t = t ^ h;
        h = (h << 16) ^ t;
        h = h + (h >> 11);
      end
      KIND_THREE: begin
        h = h + {16'd0, w[15:0]};
        h = h ^ (h << 16);
        h = h ^ (sext8(w[23:16]) << 18);
        h = h + (h >> 11);
      end
      KIND_TWO: begin
        h = h + {16'd0, w[15:0]};
        h = h ^ (h << 11);
        h = h + (h >> 17);
      end
      KIND_ONE: begin
        h = h + sext8(w[7:0]);
        h = h ^ (h << 10);
        h = h + (h >> 1);
      end
      default: begin
        h = h_in;
      end
    endcase
    return h;
  endfunction

  function automatic logic [31:0] avalanche_a(input logic [31:0] h_in);
    logic [31:0] h;
    h = h_in;
    h = h ^ (h << 3);
    h = h + (h >> 5);
    h = h ^ (h << 4);
    return h;
  endfunction

  function automatic logic [31:0] avalanche_b(input logic [31:0] h_in);
    logic [31:0] h;
    h = h_in;
    h = h + (h >> 17);
    h = h ^ (h << 25);
    h = h + (h >> 6);
    return h;
  endfunction

endpackage
`default_nettype wire

// File: design/bshf_front.sv
`default_nettype none
module bshf_front #(
  parameter int unsigned DEPTH = bshf_pkg::FIFO_DEPTH
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [bshf_pkg::WORD_W-1:0]   in_data_word,
  input  wire logic [bshf_pkg::COUNT_W-1:0]  in_byte_count,
  input  wire logic [bshf_pkg::LEN_W-1:0]    in_total_length,
  input  wire logic                          in_first_word,
  input  wire logic                          in_last_word,
  output logic                               head_valid,
  output bshf_pkg::item_t                    head,
  input  wire logic                          pop,
  output bshf_pkg::fifo_status_t             status
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  bshf_pkg::item_t entries_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic push;
  bshf_pkg::item_t new_item;

  always_comb begin
    new_item.word  = in_data_word;
    new_item.kind  = bshf_pkg::classify(in_byte_count);
    new_item.seed  = in_total_length;
    new_item.first = in_first_word;
    new_item.last  = in_last_word;
  end

  assign in_ready   = (count_r != FULL_CNT);
  assign push       = in_valid && in_ready;
  assign head_valid = (count_r != '0);
  assign head       = entries_r[rd_ptr_r];

  assign status = '{full: (count_r == FULL_CNT), empty: (count_r == '0), pop: pop};

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= new_item;
    end
  end

endmodule
`default_nettype wire

// File: design/bshf_back.sv
`default_nettype none
module bshf_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            head_valid,
  input  wire bshf_pkg::item_t head,
  output logic                 pop,
  output logic                 fin_valid,
  output bshf_pkg::fin_t       fin,
  input  wire logic            fin_ready
);

  logic [31:0] running_hash_r, running_hash_nxt;
  logic        zero_r, zero_nxt;
  logic [31:0] base_hash;

  // A first word reseeds from the length before its own mixing
  always_comb begin
    base_hash = head.first ? {1'b0, head.seed} : running_hash_r;
    zero_nxt  = head.first ? (head.seed == '0) : zero_r;
    running_hash_nxt = bshf_pkg::mix_word(base_hash, head.word, head.kind);
  end

  // Hold a last word until the finishing stages can take it
  assign pop       = head_valid && (!head.last || fin_ready);
  assign fin_valid = head_valid && head.last;
  assign fin       = '{hash: running_hash_nxt, zero: zero_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_hash_r <= '0;
      zero_r         <= 1'b0;
    end else if (pop) begin
      running_hash_r <= running_hash_nxt;
      zero_r         <= zero_nxt;
    end
  end

endmodule
`default_nettype wire

// File: design/bshf_final.sv
`default_nettype none
module bshf_final (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            fin_valid,
  input  wire bshf_pkg::fin_t  fin,
  output logic                 fin_ready,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic [31:0]          out_hash_value
);

  logic           s1_valid_r;
  bshf_pkg::fin_t s1_r;
  logic           s2_valid_r;
  bshf_pkg::fin_t s2_r, s2_nxt;
  logic           out_valid_r;
  logic [31:0]    out_hash_r, out_hash_nxt;
  logic           out_take, s2_take, s1_take;

  assign out_take  = !out_valid_r || out_ready;
  assign s2_take   = !s2_valid_r || out_take;
  assign s1_take   = !s1_valid_r || s2_take;
  assign fin_ready = s1_take;

  always_comb begin
    s2_nxt.hash  = bshf_pkg::avalanche_a(s1_r.hash);
    s2_nxt.zero  = s1_r.zero;
    out_hash_nxt = s2_r.zero ? '0 : bshf_pkg::avalanche_b(s2_r.hash);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_take) begin
        s1_valid_r <= fin_valid;
      end
      if (s2_take) begin
        s2_valid_r <= s1_valid_r;
      end
      if (out_take) begin
        out_valid_r <= s2_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take && fin_valid) begin
      s1_r <= fin;
    end
    if (s2_take && s1_valid_r) begin
      s2_r <= s2_nxt;
    end
    if (out_take && s2_valid_r) begin
      out_hash_r <= out_hash_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_hash_value = out_hash_r;

endmodule
`default_nettype wire

// File: design/byte_string_hash_32_unit.sv
// 32-bit string hash unit (SuperFastHash style).
// Input channel: one little-endian word of the string per transaction on
// in_valid/in_ready, with in_byte_count valid bytes (fewer than four only on
// the last word), in_total_length sampled when in_first_word is set, and
// in_last_word closing the string.
// Output channel: one out_hash_value per string on out_valid/out_ready,
// emitted for each word marked last; a zero-length string gives 0.
// Throughput: one word per cycle unless a stalled receiver backs up the
// finishing stages; the back end mixes each word combinationally into the
// running hash. Path: the input queue, then stage s1, stage s2 (first
// avalanche half) and the output register (second half), which drives
// out_valid.
// A queue of FIFO_DEPTH words decouples the input side from the mixing
// side, so a stalled receiver only backs up the finishing stages, then the
// queue, and only then drops in_ready.
// Reset empties the queue and pipeline and clears the running hash.
`default_nettype none
module byte_string_hash_32_unit #(
  parameter int unsigned FIFO_DEPTH = bshf_pkg::FIFO_DEPTH
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [bshf_pkg::WORD_W-1:0]   in_data_word,
  input  wire logic [bshf_pkg::COUNT_W-1:0]  in_byte_count,
  input  wire logic [bshf_pkg::LEN_W-1:0]    in_total_length,
  input  wire logic                          in_first_word,
  input  wire logic                          in_last_word,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [bshf_pkg::WORD_W-1:0]        out_hash_value
);

  logic                   head_valid;
  bshf_pkg::item_t        head;
  logic                   pop;
  bshf_pkg::fifo_status_t status;
  logic                   fin_valid;
  bshf_pkg::fin_t         fin;
  logic                   fin_ready;

  bshf_front #(
    .DEPTH (FIFO_DEPTH)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data_word    (in_data_word),
    .in_byte_count   (in_byte_count),
    .in_total_length (in_total_length),
    .in_first_word   (in_first_word),
    .in_last_word    (in_last_word),
    .head_valid      (head_valid),
    .head            (head),
    .pop             (pop),
    .status          (status)
  );

  bshf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .fin_valid  (fin_valid),
    .fin        (fin),
    .fin_ready  (fin_ready)
  );

  bshf_final u_final (
    .clk            (clk),
    .rst_n          (rst_n),
    .fin_valid      (fin_valid),
    .fin            (fin),
    .fin_ready      (fin_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_hash_value (out_hash_value)
  );

  a_reset_clears : assert property (@(posedge clk)
    !rst_n |=> (status.empty && !out_valid))
    else $error("queue or output not cleared by reset");

  a_no_pop_empty : assert property (@(posedge clk) disable iff (!rst_n)
    status.pop |-> !status.empty)
    else $error("back end popped an empty queue");

  a_full_blocks : assert property (@(posedge clk) disable iff (!rst_n)
    status.full |-> !in_ready)
    else $error("input accepted while queue full");

  a_full_not_empty : assert property (@(posedge clk) disable iff (!rst_n)
    !(status.full && status.empty))
    else $error("queue reports full and empty together");

endmodule
`default_nettype wire

// File: tb/string_hash_checker.sv
module string_hash_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic [bshf_pkg::WORD_W-1:0]  in_data_word,
  input  logic [bshf_pkg::COUNT_W-1:0] in_byte_count,
  input  logic [bshf_pkg::LEN_W-1:0]   in_total_length,
  input  logic                         in_first_word,
  input  logic                         in_last_word,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic [bshf_pkg::WORD_W-1:0]  out_hash_value,
  output int                           fail_count,
  output int                           hashes_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [bshf_pkg::COUNT_W-1:0] FULL_WORD_BYTES = 3'd4;
  localparam int MAX_PRINTED = 200;

  logic [bshf_pkg::WORD_W-1:0] hash_acc;
  logic                        seed_zero;
  logic [bshf_pkg::WORD_W-1:0] hash_expect_q[$];
  logic [bshf_pkg::WORD_W-1:0] expected_hash;

  initial begin
    fail_count = 0;
    hashes_pending = 0;
  end

  // Fold one word into the running hash; the byte count picks the rule.
  function automatic logic [31:0] fold_word(input logic [31:0] h_in,
                                            input logic [31:0] w,
                                            input logic [2:0]  n);
    logic [31:0] h;
    logic [31:0] t;
    logic [31:0] lo;
    logic [31:0] hi;
    h  = h_in;
    lo = {16'd0, w[15:0]};
    hi = {16'd0, w[31:16]};
    if (n >= FULL_WORD_BYTES) begin
      h = h + lo;
      t = (hi << 11) ^ h;
      h = (h << 16) ^ t;
      h = h + (h >> 11);
    end else if (n == 3'd3) begin
      h = h + lo;
      h = h ^ (h << 16);
      h = h ^ ({{24{w[23]}}, w[23:16]} << 18);
      h = h + (h >> 11);
    end else if (n == 3'd2) begin
      h = h + lo;
      h = h ^ (h << 11);
      h = h + (h >> 17);
    end else if (n == 3'd1) begin
      h = h + {{24{w[7]}}, w[7:0]};
      h = h ^ (h << 10);
      h = h + (h >> 1);
    end
    return h;
  endfunction

  function automatic logic [31:0] final_scramble(input logic [31:0] h_in);
    logic [31:0] h;
    h = h_in;
    h = h ^ (h << 3);
    h = h + (h >> 5);
    h = h ^ (h << 4);
    h = h + (h >> 17);
    h = h ^ (h << 25);
    h = h + (h >> 6);
    return h;
  endfunction

  task automatic report_error(input string msg);
    if (fail_count < MAX_PRINTED) $display("ERROR @%0t: %s", $time, msg);
    fail_count++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      hash_acc = '0;
      seed_zero = 1'b0;
      hash_expect_q.delete();
      hashes_pending <= 0;
    end else begin
      // Retire the output first: a hash leaving now is never from this edge's word.
      if (out_valid && out_ready) begin
        if (hash_expect_q.size() == 0) begin
          report_error($sformatf("hash %h with no string pending", out_hash_value));
        end else begin
          expected_hash = hash_expect_q.pop_front();
          if (out_hash_value !== expected_hash)
            report_error($sformatf("hash_value got %h expected %h",
                                   out_hash_value, expected_hash));
        end
      end
      if (in_valid && in_ready) begin
        if (in_first_word) begin
          hash_acc = {1'b0, in_total_length};
          seed_zero = (in_total_length == '0);
        end
        hash_acc = fold_word(hash_acc, in_data_word, in_byte_count);
        if (in_last_word)
          hash_expect_q.push_back(seed_zero ? '0 : final_scramble(hash_acc));
      end
      hashes_pending <= hash_expect_q.size();
    end
  end

endmodule

// File: tb/byte_string_hash_32_unit_tb.sv
module byte_string_hash_32_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 20;

  logic                         clk = 1'b0;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_ready;
  logic [bshf_pkg::WORD_W-1:0]  in_data_word;
  logic [bshf_pkg::COUNT_W-1:0] in_byte_count;
  logic [bshf_pkg::LEN_W-1:0]   in_total_length;
  logic                         in_first_word;
  logic                         in_last_word;
  logic                         out_valid;
  logic                         out_ready;
  logic [bshf_pkg::WORD_W-1:0]  out_hash_value;

  int fail_count;
  int hashes_pending;
  int send_idle_pct;
  int recv_stall_pct;
  bit hold_request;
  int words_sent;
  int idle_cycles;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  byte_string_hash_32_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data_word    (in_data_word),
    .in_byte_count   (in_byte_count),
    .in_total_length (in_total_length),
    .in_first_word   (in_first_word),
    .in_last_word    (in_last_word),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_hash_value  (out_hash_value)
  );

  string_hash_checker hash_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data_word    (in_data_word),
    .in_byte_count   (in_byte_count),
    .in_total_length (in_total_length),
    .in_first_word   (in_first_word),
    .in_last_word    (in_last_word),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_hash_value  (out_hash_value),
    .fail_count      (fail_count),
    .hashes_pending  (hashes_pending)
  );

  // Offer one word after a random gap and hold it until the transaction completes.
  task automatic send_word(input logic [31:0] word, input logic [2:0] count,
                           input logic [30:0] total, input bit first, input bit last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_data_word    <= word;
    in_byte_count   <= count;
    in_total_length <= total;
    in_first_word   <= first;
    in_last_word    <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
  endtask

  task automatic send_string(input int len, input logic [30:0] seed, input bit drop_last);
    int n_words;
    int left;
    n_words = (len == 0) ? 1 : (len + 3) / 4;
    for (int i = 0; i < n_words; i++) begin
      left = len - 4 * i;
      send_word($urandom, (left >= 4) ? 3'd4 : left[2:0], seed,
                i == 0, (i == n_words - 1) && !drop_last);
    end
  endtask

  task automatic drain_hashes();
    in_valid <= 1'b0;
    @(posedge clk);
    while (hashes_pending != 0) @(posedge clk);
  endtask

  function automatic int pick_length();
    if ($urandom_range(0, 99) < 5) return $urandom_range(65, 300);
    return $urandom_range(0, 24);
  endfunction

  task automatic run_phase(input int idle_pct, input int stall_pct, input int n_words);
    int start;
    int r;
    int len;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    start = words_sent;
    while (words_sent - start < n_words) begin
      r = $urandom_range(0, 99);
      len = pick_length();
      if (r < 70) begin
        send_string(len, len[30:0], 1'b0);
      end else if (r < 76) begin
        send_string(len, 31'($urandom), 1'b0);
      end else if (r < 82) begin
        send_string(len, len[30:0], 1'b1);
      end else if (r < 88) begin
        // short word at the start of a string that goes on
        send_word($urandom, 3'($urandom_range(1, 3)), len[30:0], 1'b1, 1'b0);
        repeat ($urandom_range(0, 3)) send_word($urandom, 3'd4, 31'($urandom), 1'b0, 1'b0);
        send_word($urandom, 3'($urandom_range(0, 4)), 31'($urandom), 1'b0, 1'b1);
      end else if (r < 93) begin
        // continue from the previous hash without a first word
        repeat ($urandom_range(1, 3)) send_word($urandom, 3'd4, 31'($urandom), 1'b0, 1'b0);
        send_word($urandom, 3'($urandom_range(0, 7)), 31'($urandom), 1'b0, 1'b1);
      end else begin
        send_word($urandom, 3'($urandom_range(0, 7)), 31'($urandom),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
    end
    drain_hashes();
  endtask

  // Result side: random stalls, or one long hold-off on request.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_data_word    = '0;
    in_byte_count   = '0;
    in_total_length = '0;
    in_first_word   = 1'b0;
    in_last_word    = 1'b0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    hold_request    = 1'b0;
    words_sent      = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // word with no first word straight after reset
    send_word(32'h1234_5678, 3'd4, 31'd0, 1'b0, 1'b1);
    // empty string, and a zero seed with bytes streamed anyway
    send_word(32'hFFFF_FFFF, 3'd0, 31'd0, 1'b1, 1'b1);
    send_word(32'hFFFF_FFFF, 3'd4, 31'd0, 1'b1, 1'b0);
    send_word(32'hA5A5_5A5A, 3'd4, 31'd0, 1'b0, 1'b1);
    send_word(32'hFFFF_FFFF, 3'd4, 31'd4, 1'b1, 1'b1);
    send_word(32'h0000_0000, 3'd4, 31'h7FFF_FFFF, 1'b1, 1'b1);
    // tails, with the sign bit of the odd byte set and clear
    send_word(32'h0080_FFFF, 3'd3, 31'd3, 1'b1, 1'b1);
    send_word(32'h007F_0001, 3'd3, 31'd3, 1'b1, 1'b1);
    send_word(32'h0000_FFFF, 3'd2, 31'd2, 1'b1, 1'b1);
    send_word(32'h0000_0080, 3'd1, 31'd1, 1'b1, 1'b1);
    send_word(32'hFFFF_FF7F, 3'd1, 31'd1, 1'b1, 1'b1);
    // counts above four act as a full word
    send_word(32'hDEAD_BEEF, 3'd5, 31'd5, 1'b1, 1'b1);
    send_word(32'hDEAD_BEEF, 3'd6, 31'd6, 1'b1, 1'b1);
    send_word(32'hDEAD_BEEF, 3'd7, 31'd7, 1'b1, 1'b1);
    // empty last word
    send_word(32'h0403_0201, 3'd4, 31'd4, 1'b1, 1'b0);
    send_word(32'hFFFF_FFFF, 3'd0, 31'd0, 1'b0, 1'b1);
    // short word that is not the last one
    send_word(32'h8000_1280, 3'd1, 31'd9, 1'b1, 1'b0);
    send_word(32'h7654_3210, 3'd4, 31'd0, 1'b0, 1'b0);
    send_word(32'h00C0_FFEE, 3'd3, 31'd0, 1'b0, 1'b1);
    // keep going after a result without reseeding
    send_word(32'hCAFE_F00D, 3'd2, 31'd0, 1'b0, 1'b1);
    // drop the last word, then reseed
    send_word(32'h1111_1111, 3'd4, 31'd8, 1'b1, 1'b0);
    send_word(32'h2222_2222, 3'd4, 31'd8, 1'b1, 1'b1);
    drain_hashes();

    // hold the result side off while the sender keeps pushing
    hold_request = 1'b1;
    repeat (12) send_string($urandom_range(4, 16), 31'($urandom_range(4, 16)), 1'b0);
    drain_hashes();

    run_phase(0, 0, 350);
    run_phase(71, 0, 350);
    run_phase(0, 71, 350);
    run_phase(27, 27, 350);

    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
